### sv/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and constants shared by the first-fit heap allocator files.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_BITS = 16;
	localparam int LEN_BITS  = ADDR_BITS + 1;
	// holds request + header + guard + rounding, and that plus two headers
	localparam int NEED_BITS = ADDR_BITS + 2;
	localparam logic [LEN_BITS-1:0] HEAP_LIMIT = LEN_BITS'(1) << ADDR_BITS;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOMEM  = 3'd1;
	localparam logic [2:0] ST_DOUBLE = 3'd2;
	localparam logic [2:0] ST_BADADR = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [15:0]          request_bytes;
		logic [ADDR_BITS-1:0] payload_address;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] granted_address;
		logic                 is_busy;
		logic [LEN_BITS-1:0]  granted_length;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]  length;
		logic                 busy;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DISP, S_SRD, S_SEV, S_NRD, S_NEV, S_PRD, S_PEV,
		S_MVSTART, S_MVRD, S_MVWR, S_WRA, S_WRB, S_DONE
	} state_t;

	typedef enum logic [1:0] {RD_IDX, RD_NEXT, RD_PREV, RD_MOVE} rd_sel_t;

	typedef struct packed {
		logic       cfg_wr;
		logic       init_wr;
		logic       load;
		logic       inc;
		logic       cap_cur;
		logic       cap_nxt;
		logic       cap_prv;
		rd_sel_t    rd_sel;
		logic       mv_up_start;
		logic       mv_dn_start;
		logic       mv_wr;
		logic       wr_a;
		logic       wr_b;
		logic       push;
		logic [2:0] code;
	} ctl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       null_addr;
		logic       idx_end;
		logic       fit;
		logic       split;
		logic       full;
		logic       match;
		logic       rd_busy;
		logic       has_next;
		logic       has_prev;
		logic       mv_done;
		logic       split_q;
		logic       out_free;
	} sts_t;

endpackage

### sv/ffha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/ffha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: search, neighbor fetch, table shift, write-back and result.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	input  logic   cfg_valid,
	input  sts_t   sts,
	output ctl_t   ctl,
	output logic   idle
);

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		ctl     = '0;
		ctl.rd_sel = RD_IDX;
		ctl.code   = code_q;
		idle    = (state_q == S_IDLE);
		case (state_q)
			S_INIT: begin
				ctl.init_wr = 1'b1;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_valid) begin
					ctl.cfg_wr = 1'b1;
					state_d = S_INIT;
				end else if (req_valid) begin
					ctl.load = 1'b1;
					code_d  = ST_OK;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.op == CMD_ALLOC) begin
					state_d = S_SRD;
				end else if ((sts.op == CMD_RELEASE || sts.op == CMD_QUERY) &&
						!sts.null_addr) begin
					state_d = S_SRD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRD: begin
				if (sts.idx_end) begin
					code_d  = (sts.op == CMD_ALLOC) ? ST_NOMEM : ST_BADADR;
					state_d = S_DONE;
				end else begin
					state_d = S_SEV;
				end
			end
			S_SEV: begin
				ctl.cap_cur = 1'b1;
				if (sts.op == CMD_ALLOC) begin
					if (sts.fit) begin
						if (!sts.split) begin
							state_d = S_WRA;
						end else if (sts.full) begin
							code_d  = ST_FULL;
							state_d = S_DONE;
						end else begin
							ctl.mv_up_start = 1'b1;
							state_d = S_MVRD;
						end
					end else begin
						ctl.inc = 1'b1;
						state_d = S_SRD;
					end
				end else if (sts.match) begin
					if (sts.op == CMD_QUERY) begin
						state_d = S_DONE;
					end else if (!sts.rd_busy) begin
						code_d  = ST_DOUBLE;
						state_d = S_DONE;
					end else begin
						state_d = S_NRD;
					end
				end else begin
					ctl.inc = 1'b1;
					state_d = S_SRD;
				end
			end
			S_NRD: begin
				ctl.rd_sel = RD_NEXT;
				state_d = sts.has_next ? S_NEV : S_PRD;
			end
			S_NEV: begin
				ctl.cap_nxt = 1'b1;
				state_d = S_PRD;
			end
			S_PRD: begin
				ctl.rd_sel = RD_PREV;
				state_d = sts.has_prev ? S_PEV : S_MVSTART;
			end
			S_PEV: begin
				ctl.cap_prv = 1'b1;
				state_d = S_MVSTART;
			end
			S_MVSTART: begin
				ctl.mv_dn_start = 1'b1;
				state_d = S_MVRD;
			end
			S_MVRD: begin
				ctl.rd_sel = RD_MOVE;
				state_d = sts.mv_done ? S_WRA : S_MVWR;
			end
			S_MVWR: begin
				ctl.rd_sel = RD_MOVE;
				ctl.mv_wr = 1'b1;
				state_d = S_MVRD;
			end
			S_WRA: begin
				ctl.wr_a = 1'b1;
				state_d = (sts.op == CMD_ALLOC && sts.split_q) ? S_WRB : S_DONE;
			end
			S_WRB: begin
				ctl.wr_b = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (sts.out_free) begin
					ctl.push = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule

### sv/ffha_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_dp
// Segment table RAM, search index, neighbor registers and result register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
	parameter int MAX_SEGMENTS     = 64,
	parameter int HEADER_BYTES     = 20,
	parameter int TAIL_GUARD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	output sts_t                sts,
	input  req_t                req,
	input  logic [LEN_BITS-1:0] cfg_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp
);

	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int ENT_W = $bits(entry_t);
	localparam logic [NEED_BITS-1:0] HDR   = NEED_BITS'(HEADER_BYTES);
	localparam logic [NEED_BITS-1:0] EXTRA = NEED_BITS'(HEADER_BYTES + TAIL_GUARD_BYTES + 3);
	localparam logic [CNT_W-1:0]     MAXC  = CNT_W'(MAX_SEGMENTS);

	logic [LEN_BITS-1:0]  heap_q;
	logic [CNT_W-1:0]     count_q, idx_q, k_q;
	logic [1:0]           s_q;
	logic                 up_q, nf_q, pf_q, split_q;
	req_t                 word_q;
	logic [NEED_BITS-1:0] need_q;
	entry_t               cur_q, nxt_q, prv_q, rd_e, wr_e;
	logic                 we;
	logic [CNT_W-1:0]     waddr, raddr;
	logic [ENT_W-1:0]     rdata;
	logic [LEN_BITS-1:0]  cap_v;
	logic [NEED_BITS-1:0] tail_start, merged;
	logic [CNT_W-1:0]     idx_p1, idx_m1;
	logic [CNT_W:0]       k_plus_s;
	rsp_t                 rsp_d;

	assign rd_e     = entry_t'(rdata);
	assign idx_p1   = idx_q + CNT_W'(1);
	assign idx_m1   = idx_q - CNT_W'(1);
	assign k_plus_s = {1'b0, k_q} + (CNT_W + 1)'(s_q);
	assign tail_start = NEED_BITS'(cur_q.start) + NEED_BITS'(cur_q.length) - need_q;
	assign merged = NEED_BITS'(cur_q.length) + (nf_q ? NEED_BITS'(nxt_q.length) : '0)
		+ (pf_q ? NEED_BITS'(prv_q.length) : '0);

	always_comb begin
		cap_v = (cfg_data > HEAP_LIMIT) ? HEAP_LIMIT : cfg_data;
		cap_v[1:0] = 2'b00;
	end

	always_comb begin
		case (ctl.rd_sel)
			RD_IDX:  raddr = idx_q;
			RD_NEXT: raddr = idx_p1;
			RD_PREV: raddr = idx_m1;
			RD_MOVE: raddr = up_q ? (k_q - CNT_W'(1)) : k_plus_s[CNT_W-1:0];
			default: raddr = idx_q;
		endcase
	end

	always_comb begin
		we    = 1'b1;
		waddr = idx_q;
		wr_e  = '{start: cur_q.start, length: cur_q.length, busy: 1'b0};
		if (ctl.init_wr) begin
			waddr = '0;
			wr_e  = '{start: '0, length: heap_q, busy: 1'b0};
		end else if (ctl.mv_wr) begin
			waddr = k_q;
			wr_e  = rd_e;
		end else if (ctl.wr_a) begin
			if (word_q.cmd == CMD_ALLOC) begin
				if (split_q) begin
					waddr = idx_p1;
					wr_e  = '{start: tail_start[ADDR_BITS-1:0],
						length: need_q[LEN_BITS-1:0], busy: 1'b1};
				end else begin
					wr_e.busy = 1'b1;
				end
			end else begin
				waddr = pf_q ? idx_m1 : idx_q;
				wr_e  = '{start: pf_q ? prv_q.start : cur_q.start,
					length: merged[LEN_BITS-1:0], busy: 1'b0};
			end
		end else if (ctl.wr_b) begin
			wr_e.length = LEN_BITS'(NEED_BITS'(cur_q.length) - need_q);
		end else begin
			we = 1'b0;
		end
	end

	ffha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[IDX_W-1:0]),
		.wdata (wr_e),
		.raddr (raddr[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q    <= HEAP_LIMIT;
			count_q   <= CNT_W'(1);
			idx_q     <= '0;
			k_q       <= '0;
			s_q       <= '0;
			up_q      <= 1'b0;
			nf_q      <= 1'b0;
			pf_q      <= 1'b0;
			split_q   <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (ctl.cfg_wr) begin
				heap_q <= cap_v;
			end
			if (ctl.init_wr) begin
				count_q <= CNT_W'(1);
			end
			if (ctl.load) begin
				idx_q   <= '0;
				s_q     <= '0;
				nf_q    <= 1'b0;
				pf_q    <= 1'b0;
				split_q <= 1'b0;
			end
			if (ctl.inc) begin
				idx_q <= idx_p1;
			end
			if (ctl.cap_cur) begin
				split_q <= sts.split;
			end
			if (ctl.cap_nxt) begin
				nf_q <= !rd_e.busy;
			end
			if (ctl.cap_prv) begin
				pf_q <= !rd_e.busy;
			end
			if (ctl.mv_up_start) begin
				k_q  <= count_q;
				up_q <= 1'b1;
			end
			if (ctl.mv_dn_start) begin
				up_q <= 1'b0;
				s_q  <= 2'(nf_q) + 2'(pf_q);
				k_q  <= (nf_q && !pf_q) ? idx_p1 : idx_q;
			end
			if (ctl.mv_wr) begin
				k_q <= up_q ? (k_q - CNT_W'(1)) : (k_q + CNT_W'(1));
			end
			if (ctl.push) begin
				rsp_valid <= 1'b1;
				if (ctl.code == ST_OK) begin
					if (word_q.cmd == CMD_ALLOC && split_q) begin
						count_q <= count_q + CNT_W'(1);
					end else if (word_q.cmd == CMD_RELEASE) begin
						count_q <= count_q - CNT_W'(s_q);
					end
				end
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.status = ctl.code;
		if (ctl.code == ST_OK && word_q.cmd == CMD_ALLOC) begin
			if (split_q) begin
				rsp_d.granted_address = ADDR_BITS'(tail_start + HDR);
				rsp_d.granted_length  = need_q[LEN_BITS-1:0];
			end else begin
				rsp_d.granted_address = ADDR_BITS'(NEED_BITS'(cur_q.start) + HDR);
				rsp_d.granted_length  = cur_q.length;
			end
		end
		if (ctl.code == ST_OK && word_q.cmd == CMD_QUERY &&
				word_q.payload_address != '0) begin
			rsp_d.is_busy = cur_q.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= req;
			need_q <= (NEED_BITS'(req.request_bytes) + EXTRA) & ~NEED_BITS'(3);
		end
		if (ctl.cap_cur) begin
			cur_q <= rd_e;
		end
		if (ctl.cap_nxt) begin
			nxt_q <= rd_e;
		end
		if (ctl.cap_prv) begin
			prv_q <= rd_e;
		end
		if (ctl.push) begin
			rsp <= rsp_d;
		end
	end

	always_comb begin
		sts.op        = word_q.cmd;
		sts.null_addr = (word_q.payload_address == '0);
		sts.idx_end   = (idx_q == count_q);
		sts.fit       = !rd_e.busy && (NEED_BITS'(rd_e.length) >= need_q);
		sts.split     = NEED_BITS'(rd_e.length) > (need_q + (HDR << 1));
		sts.full      = (count_q >= MAXC);
		sts.match     = (NEED_BITS'(rd_e.start) + HDR) ==
			NEED_BITS'(word_q.payload_address);
		sts.rd_busy   = rd_e.busy;
		sts.has_next  = (idx_p1 < count_q);
		sts.has_prev  = (idx_q != '0);
		sts.mv_done   = up_q ? (k_q == idx_p1) :
			((s_q == 2'd0) || (k_plus_s >= {1'b0, count_q}));
		sts.split_q   = split_q;
		sts.out_free  = !rsp_valid || !rsp_stall;
	end

endmodule

### sv/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with split and coalescing over a segment table.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  req     | req_valid/req_stall  | req_t: cmd, request_bytes, payload_address
//  rsp     | rsp_valid/rsp_stall  | rsp_t: status, address, is_busy, length
//  cfg     | cfg_valid/cfg_ready  | heap_length (17 bits)
//
//  One command at a time. The search reads the table entries in turn
//  from the segment RAM, each in a read state and an evaluate state; a split
//  or merge then shifts the table tail one entry per read and write state pair.
//  Reset or a heap_length write rebuilds entry 0 in the init state.
//  A stalled result stays in the output register; the next command is
//  accepted meanwhile and waits at its end for the register to free.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int MAX_SEGMENTS     = 64,
	parameter int HEADER_BYTES     = 20,
	parameter int TAIL_GUARD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LEN_BITS-1:0] cfg_data
);

	ctl_t ctl;
	sts_t sts;
	logic idle;

	assign cfg_ready = idle;
	assign req_stall = !idle || cfg_valid;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.ctl       (ctl),
		.idle      (idle)
	);

	ffha_dp #(
		.MAX_SEGMENTS     (MAX_SEGMENTS),
		.HEADER_BYTES     (HEADER_BYTES),
		.TAIL_GUARD_BYTES (TAIL_GUARD_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.req       (req),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("accepted a second command while busy");

	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (req_stall && !cfg_ready))
		else $error("table rebuild skipped after heap_length write");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |->
		(rsp.granted_address == '0 && rsp.granted_length == '0))
		else $error("failed command carries a grant");

endmodule
